[design/least_loaded_dispatcher_macros.svh]
// Assertion macros shared by the least-loaded dispatcher RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef LEAST_LOADED_DISPATCHER_MACROS_SVH
`define LEAST_LOADED_DISPATCHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LLD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lld check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define LLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lld check failed: next-cycle implication");

`endif

[design/lld_pkg.sv]
// Shared types and constants of the least-loaded dispatcher.
// Used by lld_load_mem, lld_seq and least_loaded_dispatcher; depends on nothing.
`default_nettype none

package lld_pkg;

	localparam int LOAD_W = 32;
	localparam int ID_W = 16;
	localparam int SIZE_W = 16;
	localparam int SEL_W = 3;
	localparam int CNT_W = 4;

	localparam logic [CNT_W-1:0] ACTIVE_RESET = 4'd8;

	// tdata layouts, padded to whole bytes.
	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 56;

	localparam logic ACT_ASSIGN = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctrl_t;

	typedef struct packed {
		logic [SEL_W-1:0]  worker_index;
		logic [ID_W-1:0]   job_echo;
		logic [LOAD_W-1:0] worker_load;
		logic              saturated;
	} res_t;

endpackage

`default_nettype wire

[design/lld_load_mem.sv]
// Per-worker load store: one write and one registered read port a cycle.
// Entries read as zero until first written. Depends on lld_pkg.
`default_nettype none

module lld_load_mem #(
	parameter int DEPTH = 8,
	parameter int AW = 3
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  lld_pkg::mem_ctrl_t        ctrl,
	input  wire  [AW-1:0]             rd_addr,
	output logic [lld_pkg::LOAD_W-1:0] rd_data,
	input  wire  [AW-1:0]             wr_addr,
	input  wire  [lld_pkg::LOAD_W-1:0] wr_data
);
	import lld_pkg::*;

	logic [LOAD_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [LOAD_W-1:0] rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctrl.wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// An entry never written since reset reads as a zero load.
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem_q[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[design/lld_seq.sv]
// Sequencer of the dispatcher: an assign walks the loads through one shared comparator,
// then adds the job size with saturation; a read returns one load. Depends on lld_pkg.
`default_nettype none

module lld_seq #(
	parameter int MAX_WORKERS = 8,
	parameter int AW = 3
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire                        in_action,
	input  wire  [lld_pkg::ID_W-1:0]   in_job_id,
	input  wire  [lld_pkg::SIZE_W-1:0] in_job_size,
	input  wire  [lld_pkg::SEL_W-1:0]  in_sel,
	input  wire  [lld_pkg::CNT_W-1:0]  active_workers,
	output lld_pkg::mem_ctrl_t         mem_ctrl,
	output logic [AW-1:0]              mem_rd_addr,
	input  wire  [lld_pkg::LOAD_W-1:0] mem_rd_data,
	output logic [AW-1:0]              mem_wr_addr,
	output logic [lld_pkg::LOAD_W-1:0] mem_wr_data,
	output logic                       res_valid,
	input  wire                        res_ready,
	output lld_pkg::res_t              res
);
	import lld_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_UPDATE = 4'b0100,
		S_RDRES  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [ID_W-1:0]   id_q;
	logic [SIZE_W-1:0] size_q;
	logic [SEL_W-1:0]  sel_q;
	logic              sel_ok_q;
	logic [AW-1:0]     last_idx_q;
	logic [AW-1:0]     cmp_idx_q;
	logic [AW-1:0]     best_idx_q;
	logic [LOAD_W-1:0] best_load_q;

	logic              sel_ok;
	logic [AW-1:0]     last_idx;
	logic              take;
	logic [LOAD_W:0]   sum;
	logic              clip;
	logic [LOAD_W-1:0] new_load;

	// Zero active workers counts as one; a count beyond the store is clipped.
	always_comb begin
		if (active_workers == '0) begin
			last_idx = '0;
		end else if (32'(active_workers) > MAX_WORKERS) begin
			last_idx = AW'(MAX_WORKERS - 1);
		end else begin
			last_idx = AW'(active_workers - 4'd1);
		end
	end

	assign sel_ok = 32'(in_sel) < MAX_WORKERS;
	assign in_ready = (state_q == S_IDLE);

	// Shared comparator: the first entry always wins, later ones only if smaller,
	// so a tie keeps the lowest index.
	assign take = (cmp_idx_q == '0) || (mem_rd_data < best_load_q);

	assign sum = {1'b0, best_load_q} + {{(LOAD_W + 1 - SIZE_W){1'b0}}, size_q};
	assign clip = sum[LOAD_W];
	assign new_load = clip ? '1 : sum[LOAD_W-1:0];

	always_comb begin
		mem_ctrl = '0;
		mem_rd_addr = cmp_idx_q + AW'(1);
		mem_wr_addr = best_idx_q;
		mem_wr_data = new_load;
		res_valid = 1'b0;
		res.worker_index = SEL_W'(best_idx_q);
		res.job_echo = id_q;
		res.worker_load = new_load;
		res.saturated = clip;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_action == ACT_ASSIGN) begin
						mem_ctrl.rd_en = 1'b1;
						mem_rd_addr = '0;
					end else begin
						mem_ctrl.rd_en = sel_ok;
						mem_rd_addr = AW'(in_sel);
					end
				end
			end
			S_SCAN: begin
				mem_ctrl.rd_en = (cmp_idx_q != last_idx_q);
			end
			S_UPDATE: begin
				res_valid = 1'b1;
				mem_ctrl.wr_en = res_ready;
			end
			S_RDRES: begin
				res_valid = 1'b1;
				res.worker_index = sel_q;
				res.job_echo = '0;
				res.worker_load = sel_ok_q ? mem_rd_data : '0;
				res.saturated = 1'b0;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (in_action == ACT_READ) ? S_RDRES : S_SCAN;
					end
				end
				S_SCAN: begin
					if (cmp_idx_q == last_idx_q) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE, S_RDRES: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			if (in_valid) begin
				id_q <= in_job_id;
				size_q <= in_job_size;
				sel_q <= in_sel;
				sel_ok_q <= sel_ok;
				last_idx_q <= last_idx;
				cmp_idx_q <= '0;
			end
		end else if (state_q == S_SCAN) begin
			if (take) begin
				best_idx_q <= cmp_idx_q;
				best_load_q <= mem_rd_data;
			end
			if (cmp_idx_q != last_idx_q) begin
				cmp_idx_q <= cmp_idx_q + AW'(1);
			end
		end
	end

endmodule

`default_nettype wire

[design/least_loaded_dispatcher.sv]
// Least-loaded job dispatcher: top level with the configuration register and
// the result register. Depends on lld_pkg, lld_load_mem, lld_seq and the macro header.
//
// Usage:
// Input transactions arrive on s_axis_*. tuser carries the action (0 assigns a
// job, 1 reads one worker's load); tdata carries job_id, job_size and
// worker_select. Each input transaction yields exactly one result transaction on
// m_axis_*, giving the worker index, the echoed job id, the worker's load
// and a saturation flag.
// An assign transaction scans N stored loads before its result, where N is
// the effective number of active workers: the sequencer reads one stored load
// per cycle into a single shared comparator. A read transaction reads a single
// stored load. The input is not ready while a transaction is in progress, so a
// new input transaction is accepted only once the last one has left the sequencer.
// The result sits in an output register, so the next input can be accepted
// while a result waits; if the receiver stalls, the sequencer holds its finished
// result (and the load write-back) until the register frees up.
// Reset clears every worker load to zero at once, sets active_workers to 8 and
// empties the result register. The active worker count is written through
// cfg_wr_en and cfg_wr_data; the user must write it only while the block is idle, which the block does not enforce.
`default_nettype none

`include "least_loaded_dispatcher_macros.svh"

module least_loaded_dispatcher #(
	parameter int MAX_WORKERS = 8
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_wr_en,
	input  wire  [lld_pkg::CNT_W-1:0]           cfg_wr_data,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// [15:0] job_id, [31:16] job_size, [34:32] worker_select, rest zero
	input  wire  [lld_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// [0] action
	input  wire  [0:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// [2:0] worker_index, [18:3] job_echo, [50:19] worker_load, rest zero
	output logic [lld_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// [0] saturated
	output logic [0:0]                          m_axis_tuser
);
	import lld_pkg::*;

	localparam int AW = $clog2(MAX_WORKERS);

	logic [CNT_W-1:0]  active_q;
	logic              out_valid_q;
	res_t              out_res_q;

	mem_ctrl_t         mem_ctrl;
	logic [AW-1:0]     mem_rd_addr;
	logic [LOAD_W-1:0] mem_rd_data;
	logic [AW-1:0]     mem_wr_addr;
	logic [LOAD_W-1:0] mem_wr_data;
	logic              res_valid;
	logic              res_ready;
	res_t              res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_wr_en) begin
			active_q <= cfg_wr_data;
		end
	end

	lld_load_mem #(
		.DEPTH(MAX_WORKERS),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(mem_ctrl),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data)
	);

	lld_seq #(
		.MAX_WORKERS(MAX_WORKERS),
		.AW(AW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_action(s_axis_tuser[0]),
		.in_job_id(s_axis_tdata[15:0]),
		.in_job_size(s_axis_tdata[31:16]),
		.in_sel(s_axis_tdata[34:32]),
		.active_workers(active_q),
		.mem_ctrl(mem_ctrl),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// The result register takes a new result when empty or being emptied.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {
		{(OUT_TDATA_W - SEL_W - ID_W - LOAD_W){1'b0}},
		out_res_q.worker_load,
		out_res_q.job_echo,
		out_res_q.worker_index
	};
	assign m_axis_tuser = out_res_q.saturated;

	`LLD_ASSERT_SAME(a_wr_only_on_handover, clk, arst_n, mem_ctrl.wr_en, res_valid && res_ready)
	`LLD_ASSERT_SAME(a_no_rd_wr_clash, clk, arst_n, mem_ctrl.rd_en, !mem_ctrl.wr_en)
	`LLD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`LLD_ASSERT_SAME(a_sat_at_max, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[50:19] == 32'hFFFF_FFFF)

endmodule

`default_nettype wire

[bench/tb_least_loaded_dispatcher.sv]
`timescale 1ns / 100ps
// Self-checking bench for least_loaded_dispatcher: directed and random assign and
// read transactions, checked against a behavioural tracker of the worker loads.
// Depends on lld_pkg and the dispatcher RTL.

localparam int DISPATCH_WORKERS = 8;

class dispatch_tracker;
	logic [lld_pkg::LOAD_W-1:0] worker_totals [DISPATCH_WORKERS];
	logic [lld_pkg::CNT_W-1:0]  active_setting;
	lld_pkg::res_t              awaited_results [$];
	int unsigned                mismatches;
	int unsigned                assigns;
	int unsigned                reads;
	int unsigned                clipped;

	function new();
		foreach (worker_totals[k]) worker_totals[k] = '0;
		active_setting = lld_pkg::ACTIVE_RESET;
		mismatches = 0;
		assigns = 0;
		reads = 0;
		clipped = 0;
	endfunction

	function int unsigned search_span();
		int unsigned n;
		n = active_setting;
		// A count of zero still searches worker 0; a large count is clipped.
		if (n == 0) n = 1;
		if (n > DISPATCH_WORKERS) n = DISPATCH_WORKERS;
		return n;
	endfunction

	function int unsigned least_loaded();
		int unsigned best;
		int unsigned k;
		best = 0;
		for (k = 1; k < search_span(); k++)
			if (worker_totals[k] < worker_totals[best]) best = k;
		return best;
	endfunction

	function void accept_request(input logic action, input logic [lld_pkg::ID_W-1:0] job_id,
			input logic [lld_pkg::SIZE_W-1:0] job_size,
			input logic [lld_pkg::SEL_W-1:0] worker_select);
		lld_pkg::res_t             r;
		int unsigned               best;
		logic [lld_pkg::LOAD_W:0]  sum;
		r = '0;
		if (action == lld_pkg::ACT_ASSIGN) begin
			best = least_loaded();
			sum = {1'b0, worker_totals[best]} + job_size;
			if (sum[lld_pkg::LOAD_W]) begin
				sum = {1'b0, {lld_pkg::LOAD_W{1'b1}}};
				r.saturated = 1'b1;
				clipped++;
			end
			worker_totals[best] = sum[lld_pkg::LOAD_W-1:0];
			r.worker_index = best[lld_pkg::SEL_W-1:0];
			r.job_echo = job_id;
			r.worker_load = worker_totals[best];
			assigns++;
		end else begin
			r.worker_index = worker_select;
			if (worker_select < DISPATCH_WORKERS)
				r.worker_load = worker_totals[worker_select];
			reads++;
		end
		awaited_results.push_back(r);
	endfunction

	function void compare_result(input logic [lld_pkg::OUT_TDATA_W-1:0] data,
			input logic [0:0] user);
		lld_pkg::res_t want;
		lld_pkg::res_t got;
		got.worker_index = data[lld_pkg::SEL_W-1:0];
		got.job_echo = data[lld_pkg::SEL_W +: lld_pkg::ID_W];
		got.worker_load = data[lld_pkg::SEL_W + lld_pkg::ID_W +: lld_pkg::LOAD_W];
		got.saturated = user[0];
		if (awaited_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Unexpected result: index %0d job %h load %h sat %b",
					got.worker_index, got.job_echo, got.worker_load, got.saturated);
			return;
		end
		want = awaited_results.pop_front();
		if (got.worker_index !== want.worker_index || got.job_echo !== want.job_echo ||
				got.worker_load !== want.worker_load || got.saturated !== want.saturated) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Mismatch: want idx %0d job %h load %h sat %b, got %0d %h %h %b",
					want.worker_index, want.job_echo, want.worker_load, want.saturated,
					got.worker_index, got.job_echo, got.worker_load, got.saturated);
		end
	endfunction
endclass

module tb_least_loaded_dispatcher;
	import lld_pkg::*;

	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 35;
	localparam int TAIL_ITEMS = 40;
	localparam int LONG_STALL = 200;
	localparam int SETTLE_CYCLES = DISPATCH_WORKERS + 4;
	localparam int CYCLE_LIMIT = 2000000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CNT_W-1:0]      cfg_wr_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic [0:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [0:0]            m_axis_tuser;

	dispatch_tracker tracker = new();

	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned stall_left = 0;
	bit          long_stall_req = 1'b0;
	int unsigned cfg_writes = 0;
	int unsigned cycle_count = 0;

	least_loaded_dispatcher #(.MAX_WORKERS(DISPATCH_WORKERS)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: check each transaction, then decide whether to stall next cycle.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.compare_result(m_axis_tdata, m_axis_tuser);
		if (stall_left != 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (long_stall_req) begin
			long_stall_req = 1'b0;
			stall_left = LONG_STALL - 1;
			m_axis_tready <= 1'b0;
		end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
			stall_left = $urandom_range(14, 0);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_request(input logic action, input logic [ID_W-1:0] job_id,
			input logic [SIZE_W-1:0] job_size, input logic [SEL_W-1:0] worker_select);
		int unsigned gap;
		gap = 0;
		if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct)
			gap = $urandom_range(15, 1);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= action;
		s_axis_tdata <= {{(IN_TDATA_W - SEL_W - SIZE_W - ID_W){1'b0}},
			worker_select, job_size, job_id};
		do @(posedge clk); while (!s_axis_tready);
		tracker.accept_request(action, job_id, job_size, worker_select);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (tracker.awaited_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_active(input logic [CNT_W-1:0] value);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.active_setting = value;
		cfg_writes++;
	endtask

	task automatic send_random_batch(input int unsigned count);
		bit [31:0]         rnd;
		logic              action;
		logic [SIZE_W-1:0] job_size;
		logic [LOAD_W-1:0] spread;
		int unsigned       best;
		int unsigned       k;
		repeat (count) begin
			rnd = $urandom;
			action = ($urandom_range(3, 0) == 0) ? ACT_READ : ACT_ASSIGN;
			case ($urandom_range(5, 0))
				0: job_size = '0;
				1: job_size = '1;
				2: job_size = rnd[19:16];
				3: begin
					// Pick the size that brings the chosen worker level with the next
					// lightest one, so that the following search meets a tie.
					best = tracker.least_loaded();
					spread = '1;
					for (k = 0; k < tracker.search_span(); k++)
						if (k != best &&
								tracker.worker_totals[k] - tracker.worker_totals[best] < spread)
							spread = tracker.worker_totals[k] - tracker.worker_totals[best];
					job_size = (spread <= 32'h0000_FFFF) ? spread[SIZE_W-1:0] : rnd[31:16];
				end
				default: job_size = rnd[31:16];
			endcase
			send_request(action, rnd[15:0], job_size, rnd[18:16] ^ rnd[2:0]);
		end
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles.", cycle_count);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		logic [CNT_W-1:0] cfg_plan [PHASES];
		bit [31:0]        rnd;
		int unsigned      phase;
		int unsigned      k;
		cfg_plan = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'd7, 4'd4, 4'd9, 4'd3, 4'd5};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty loads, zero and full sizes, ties, count edges.
		send_request(ACT_READ, 16'h0000, 16'h0000, 3'd0);
		send_request(ACT_READ, 16'hFFFF, 16'hFFFF, 3'd7);
		send_request(ACT_ASSIGN, 16'h0000, 16'h0000, 3'd0);
		send_request(ACT_ASSIGN, 16'hFFFF, 16'hFFFF, 3'd7);
		for (k = 1; k < DISPATCH_WORKERS; k++)
			send_request(ACT_ASSIGN, 16'hAAAA ^ k[15:0], k[15:0], 3'd5);
		send_request(ACT_ASSIGN, 16'h5555, 16'h0010, 3'd2);
		send_request(ACT_READ, 16'h1234, 16'h4321, 3'd3);
		write_active(4'd3);
		send_request(ACT_ASSIGN, 16'h0F0F, 16'h0005, 3'd0);
		send_request(ACT_READ, 16'h0000, 16'h0000, 3'd6);
		write_active(4'd0);
		send_request(ACT_ASSIGN, 16'hF0F0, 16'h0001, 3'd4);
		send_request(ACT_READ, 16'h0000, 16'h0000, 3'd0);
		write_active(4'd15);
		send_request(ACT_ASSIGN, 16'h00FF, 16'h0009, 3'd1);
		write_active(4'd1);
		send_request(ACT_ASSIGN, 16'hFF00, 16'hFFFF, 3'd6);
		send_request(ACT_READ, 16'h0000, 16'h0000, 3'd0);

		// Random phases with changing idling and a long result stall now and then.
		for (phase = 0; phase < PHASES; phase++) begin
			write_active(cfg_plan[phase]);
			case ($urandom_range(2, 0))
				0: gap_pct = 0;
				1: gap_pct = 15;
				default: gap_pct = 40;
			endcase
			case ($urandom_range(2, 0))
				0: stall_pct = 0;
				1: stall_pct = 15;
				default: stall_pct = 40;
			endcase
			if (phase == 2 || phase == 7)
				long_stall_req = 1'b1;
			send_random_batch(PHASE_ITEMS);
		end

		// Closing part without idling: a single worker, then the full set, then a random count.
		gap_pct = 0;
		stall_pct = 0;
		write_active(4'd1);
		send_random_batch(TAIL_ITEMS);
		write_active(4'd8);
		send_random_batch(TAIL_ITEMS);
		rnd = $urandom;
		write_active(rnd[CNT_W-1:0]);
		send_random_batch(TAIL_ITEMS);

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d assign and %0d read transactions, %0d of them clipped,",
			tracker.assigns, tracker.reads, tracker.clipped);
		$display("across %0d writes of the active worker count; %0d mismatches seen.",
			cfg_writes, tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.awaited_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/lld_pkg.sv
design/lld_load_mem.sv
design/lld_seq.sv
design/least_loaded_dispatcher.sv
bench/tb_least_loaded_dispatcher.sv
